@@ rtl/lvt_pkg.sv @@
`default_nettype none

package lvt_pkg;

  // Field widths of one item.
  localparam int unsigned CmdW   = 1;
  localparam int unsigned TblW   = 3;
  localparam int unsigned LineW  = 12;
  localparam int unsigned TagW   = 16;
  localparam int unsigned StartW = 12;
  localparam int unsigned EndW   = 13;
  localparam int unsigned KeyW   = 32;

  // Input tdata: table_select, line_index, tag, range_start, range_end, padded to 7 bytes.
  localparam int unsigned InDataW  = 56;
  // Output tdata: victim_line, padded to 2 bytes.
  localparam int unsigned OutDataW = 16;

  // Command codes carried in tuser.
  localparam logic [CmdW-1:0] CMD_ACCESS = 1'b0;
  localparam logic [CmdW-1:0] CMD_VICTIM = 1'b1;

  // Victim key selection.
  localparam logic KEY_LRU = 1'b0;
  localparam logic KEY_LFU = 1'b1;

  // Control of the shared minimum compare unit.
  typedef struct packed {
    logic             clear;
    logic             en;
    logic [LineW-1:0] line;
  } min_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lvt_min_unit.sv @@
`default_nettype none

module lvt_min_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lvt_pkg::min_ctl_t             ctl_i,
  input  wire logic [lvt_pkg::KeyW-1:0]      key_i,
  output logic      [lvt_pkg::LineW-1:0]     best_line_o,
  output logic                               found_o
);
  import lvt_pkg::*;

  logic [KeyW-1:0]  best_key_q, best_key_d;
  logic [LineW-1:0] best_line_q, best_line_d;
  logic             found_q, found_d;

  // A key equal to the best so far replaces it, so the later line wins a tie.
  always_comb begin
    best_key_d  = best_key_q;
    best_line_d = best_line_q;
    found_d     = found_q;
    if (ctl_i.clear) begin
      best_line_d = '0;
      found_d     = 1'b0;
    end else if (ctl_i.en && (!found_q || key_i <= best_key_q)) begin
      best_key_d  = key_i;
      best_line_d = ctl_i.line;
      found_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_line_q <= '0;
    end else begin
      found_q     <= found_d;
      best_line_q <= best_line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
  end

  assign best_line_o = best_line_q;
  assign found_o     = found_q;

endmodule

`default_nettype wire

@@ rtl/lru_lfu_victim_tracker.sv @@
`default_nettype none

// Replacement bookkeeping for several cache tables.
// Input channel s_axis: one item per command. tuser carries the command (access or
// victim search); tdata carries table_select, line_index, tag, range_start, range_end.
// Output channel m_axis: exactly one item per input item. tdata carries victim_line
// and tuser carries found. Access items always return line 0, found 0.
// The configuration write port selects the victim key: timestamp (LRU) or access
// count (LFU). Write it only while the block is idle.
// After reset the block sweeps the timestamp/count memory to zero, one entry per
// cycle, TABLES*LINES entries in all (20480 at the defaults); tready stays low then.
// One item is worked on at a time through a timestamp/count memory with one read
// port and one write port, and one shared compare unit. An access passes through a
// read, a write back and a result stage, and the block is ready for the next item
// as its result is loaded. A victim search reads one line per cycle, then drains
// the last read into the compare unit before its result stage. An empty range or a
// bad table goes straight to the result stage. Memory read bandwidth sets the
// search time.
// A finished result sits in the output register. While the receiver stalls, the
// block still takes the next item and works on it, then holds in its last step until
// the waiting result has been taken.
module lru_lfu_victim_tracker #(
  parameter int unsigned TABLES = 5,
  parameter int unsigned LINES  = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_wdata_i,   // victim_key
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] table_select, [14:3] line_index, [30:15] tag, [42:31] range_start,
  // [55:43] range_end
  input  wire logic [lvt_pkg::InDataW-1:0]     s_axis_tdata,
  input  wire logic [lvt_pkg::CmdW-1:0]        s_axis_tuser,  // [0] command
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [lvt_pkg::OutDataW-1:0]    m_axis_tdata,  // [11:0] victim_line
  output logic                                 m_axis_tuser   // [0] found
);
  import lvt_pkg::*;

  localparam int unsigned Slots = TABLES * LINES;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned IdxW  = $clog2(LINES + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ACC_RD = 3'd2;
  localparam logic [2:0] S_ACC_WR = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  // Input field unpacking.
  logic [TblW-1:0]   in_tbl;
  logic [LineW-1:0]  in_line;
  logic [TagW-1:0]   in_tag;
  logic [StartW-1:0] in_start;
  logic [EndW-1:0]   in_end;

  assign in_tbl   = s_axis_tdata[2:0];
  assign in_line  = s_axis_tdata[14:3];
  assign in_tag   = s_axis_tdata[30:15];
  assign in_start = s_axis_tdata[42:31];
  assign in_end   = s_axis_tdata[55:43];

  logic [2:0]        state_q, state_d;
  logic [SlotW-1:0]  clr_idx_q, clr_idx_d;
  logic [SlotW-1:0]  addr_q, addr_d;
  logic [SlotW-1:0]  base_q, base_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   hi_q, hi_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic [KeyW-1:0]   time_q, time_d;
  logic              victim_key_q;
  logic              rd_vld_q;
  logic [LineW-1:0]  rd_line_q;
  logic              m_valid_q, m_valid_d;
  logic [LineW-1:0]  m_line_q, m_line_d;
  logic              m_found_q, m_found_d;

  // Timestamp in the low half, access count in the high half.
  logic [2*KeyW-1:0] mem_q [Slots];
  logic [TagW-1:0]   tag_mem_q [Slots];
  logic [2*KeyW-1:0] rd_data_q;
  logic              mem_we;
  logic [SlotW-1:0]  mem_waddr;
  logic [2*KeyW-1:0] mem_wdata;
  logic [SlotW-1:0]  mem_raddr;

  min_ctl_t          min_ctl;
  logic [KeyW-1:0]   min_key;
  logic [LineW-1:0]  best_line;
  logic              best_found;

  logic              accept;
  logic              out_free;
  logic [31:0]       hi_clamped;
  logic              tbl_ok;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign tbl_ok   = 32'(in_tbl) < 32'(TABLES);
  assign hi_clamped = (32'(in_end) > 32'(LINES)) ? 32'(LINES) : 32'(in_end);

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    addr_d    = addr_q;
    base_d    = base_q;
    idx_d     = idx_q;
    hi_d      = hi_q;
    tag_d     = tag_q;
    time_d    = time_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_line_d  = m_line_q;
    m_found_d = m_found_q;
    min_ctl.clear = 1'b0;
    min_ctl.en    = rd_vld_q;
    min_ctl.line  = rd_line_q;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SlotW'(Slots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          // Every item starts from a cleared compare unit, so access items and
          // empty searches report line 0, not found.
          min_ctl.clear = 1'b1;
          base_d = SlotW'(32'(in_tbl) * 32'(LINES));
          addr_d = SlotW'(32'(in_tbl) * 32'(LINES) + 32'(in_line));
          tag_d  = in_tag;
          idx_d  = IdxW'(in_start);
          hi_d   = IdxW'(hi_clamped);
          if (s_axis_tuser == CMD_ACCESS) begin
            state_d = (tbl_ok && 32'(in_line) < 32'(LINES)) ? S_ACC_RD : S_FINISH;
          end else begin
            state_d = (tbl_ok && 32'(in_start) < hi_clamped) ? S_SCAN : S_FINISH;
          end
        end
      end
      S_ACC_RD: begin
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        time_d  = time_q + 1'b1;
        state_d = S_FINISH;
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == hi_q - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_line_d  = best_line;
          m_found_d = best_found;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port muxing: the clearing sweep and the access write back share the
  // write port; the read port serves the access read and the range walk.
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_ACC_WR);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_idx_q : addr_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0
                   : {rd_data_q[2*KeyW-1:KeyW] + 1'b1, time_q};
  assign mem_raddr = (state_q == S_SCAN) ? base_q + SlotW'(idx_q) : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // Tags are kept for the cache but never read back by this block.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACC_WR) begin
      tag_mem_q[addr_q] <= tag_q;
    end
  end

  assign min_key = (victim_key_q == KEY_LFU) ? rd_data_q[2*KeyW-1:KeyW]
                                             : rd_data_q[KeyW-1:0];

  lvt_min_unit u_min (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (min_ctl),
    .key_i       (min_key),
    .best_line_o (best_line),
    .found_o     (best_found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      time_q       <= '0;
      victim_key_q <= KEY_LRU;
      rd_vld_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      time_q    <= time_d;
      rd_vld_q  <= (state_q == S_SCAN);
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        victim_key_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    base_q    <= base_d;
    idx_q     <= idx_d;
    hi_q      <= hi_d;
    tag_q     <= tag_d;
    rd_line_q <= LineW'(idx_q);
    m_line_q  <= m_line_d;
    m_found_q <= m_found_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - LineW){1'b0}}, m_line_q};
  assign m_axis_tuser  = m_found_q;

  // One item at a time: an accepted item closes the input until it is finished.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // The time counter moves only on the write back of an access.
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_ACC_WR |=> time_q == $past(time_q))
    else $error("time counter changed outside an access write back");

  // Compare data only arrives while a range walk is in flight.
  a_scan_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("compare data outside a range walk");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && m_valid_q && !m_axis_tready) |=> state_q == S_FINISH)
    else $error("result left finish while output stalled");

endmodule

`default_nettype wire
